FILE: sv/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBBPT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Assertion lbl failed.");

// The consequent must hold in the cycle after the antecedent.
`define OBBPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Assertion lbl failed.");

`endif

FILE: sv/obbpt_pkg.sv
// Shared types, constants and search functions of the order book tracker.
package obbpt_pkg;

  localparam int PRICE_LEVELS = 4096;
  localparam int ORDER_SLOTS  = 16384;

  localparam int MASK_WORDS = (PRICE_LEVELS + 63) / 64;
  localparam int WORD_W     = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
  localparam int SUM_N      = 1 << WORD_W;
  localparam int LVL_W      = WORD_W + 6;
  localparam int ID_W       = $clog2(ORDER_SLOTS);
  localparam int CNT_W      = $clog2(ORDER_SLOTS + 1);
  localparam int QTY_W      = 32;
  localparam int BEST_W     = 12;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_REDUCE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_BAD_PRICE     = 3'd1;
  localparam logic [2:0] ST_ZERO_QTY      = 3'd2;
  localparam logic [2:0] ST_BAD_ID        = 3'd3;
  localparam logic [2:0] ST_DUPLICATE     = 3'd4;
  localparam logic [2:0] ST_NOT_LIVE      = 3'd5;
  localparam logic [2:0] ST_NOT_REDUCTION = 3'd6;

  typedef struct packed {
    op_e              op;
    logic [ID_W-1:0]  id;
    logic             side;
    logic [LVL_W-1:0] lvl;
    logic [QTY_W-1:0] qty;
    logic [2:0]       pre_status;
  } cmd_t;

  typedef struct packed {
    logic             live;
    logic             side;
    logic [LVL_W-1:0] lvl;
    logic [QTY_W-1:0] qty;
  } entry_t;

  function automatic logic [6:0] hi_bit64(input logic [63:0] v);
    logic [6:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = {1'b1, 6'(i)};
    end
    return r;
  endfunction

  function automatic logic [6:0] lo_bit64(input logic [63:0] v);
    logic [6:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = {1'b1, 6'(i)};
    end
    return r;
  endfunction

  function automatic logic [WORD_W:0] hi_bit_sum(input logic [SUM_N-1:0] v);
    logic [WORD_W:0] r;
    r = '0;
    for (int i = 0; i < SUM_N; i++) begin
      if (v[i]) r = {1'b1, WORD_W'(i)};
    end
    return r;
  endfunction

  function automatic logic [WORD_W:0] lo_bit_sum(input logic [SUM_N-1:0] v);
    logic [WORD_W:0] r;
    r = '0;
    for (int i = SUM_N - 1; i >= 0; i--) begin
      if (v[i]) r = {1'b1, WORD_W'(i)};
    end
    return r;
  endfunction

endpackage

FILE: sv/order_book_best_price_tracker.sv
// Top level of the price-level order book with best bid and ask tracking.
// An add, a cancel or a reduce to zero goes through the back-end steps pop,
// order table read, level count and mask read-modify-write, result register.
// When it empties the best level and no other 64-level mask word of that side
// holds a level, a word summary search comes before the result register; when
// the next best lies in another mask word, one more mask read follows it. A
// reduce that keeps the order live, a duplicate add, and a cancel or reduce of
// an order that is not live skip the level step. Items rejected by the front
// end range checks and clears go from pop to the result register. After reset
// and after every clear the order table is swept one entry a cycle, while no
// word is taken; a two-entry queue between front and back absorbs short stalls.
module order_book_best_price_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [31:0]        order_id_i,
  input  logic               side_i,
  input  logic signed [31:0] price_i,
  input  logic [31:0]        quantity_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               accepted_o,
  output logic [2:0]         status_o,
  output logic               best_bid_valid_o,
  output logic [11:0]        best_bid_o,
  output logic               best_ask_valid_o,
  output logic [11:0]        best_ask_o
);

  obbpt_pkg::cmd_t cmd;
  logic            cmd_valid, cmd_pop, busy;

  obbpt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .order_id_i  (order_id_i),
    .side_i      (side_i),
    .price_i     (price_i),
    .quantity_i  (quantity_i),
    .busy_i      (busy),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  obbpt_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cmd_valid_i      (cmd_valid),
    .cmd_pop_o        (cmd_pop),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .accepted_o       (accepted_o),
    .status_o         (status_o),
    .best_bid_valid_o (best_bid_valid_o),
    .best_bid_o       (best_bid_o),
    .best_ask_valid_o (best_ask_valid_o),
    .best_ask_o       (best_ask_o)
  );

endmodule

FILE: sv/obbpt_front.sv
// Front end: accepts words, runs the range checks and queues commands.
module obbpt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            op_i,
  input  logic [31:0]           order_id_i,
  input  logic                  side_i,
  input  logic signed [31:0]    price_i,
  input  logic [31:0]           quantity_i,
  input  logic                  busy_i,
  output obbpt_pkg::cmd_t       cmd_o,
  output logic                  cmd_valid_o,
  input  logic                  cmd_pop_i
);

  obbpt_pkg::cmd_t fifo_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  obbpt_pkg::cmd_t cmd_new;
  logic            bad_price, bad_id, push;

  always_comb begin
    bad_price = $unsigned(price_i) >= 32'(obbpt_pkg::PRICE_LEVELS);
    bad_id    = order_id_i >= 32'(obbpt_pkg::ORDER_SLOTS);
    cmd_new.op   = obbpt_pkg::op_e'(op_i);
    cmd_new.id   = order_id_i[obbpt_pkg::ID_W-1:0];
    cmd_new.side = side_i;
    cmd_new.lvl  = price_i[obbpt_pkg::LVL_W-1:0];
    cmd_new.qty  = quantity_i;
    cmd_new.pre_status = obbpt_pkg::ST_OK;
    unique case (cmd_new.op)
      obbpt_pkg::OP_ADD: begin
        if (bad_price) cmd_new.pre_status = obbpt_pkg::ST_BAD_PRICE;
        else if (quantity_i == '0) cmd_new.pre_status = obbpt_pkg::ST_ZERO_QTY;
        else if (bad_id) cmd_new.pre_status = obbpt_pkg::ST_BAD_ID;
      end
      obbpt_pkg::OP_CANCEL, obbpt_pkg::OP_REDUCE: begin
        if (bad_id) cmd_new.pre_status = obbpt_pkg::ST_BAD_ID;
      end
      default: cmd_new.pre_status = obbpt_pkg::ST_OK;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2) && !busy_i;
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    cnt_d    = cnt_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd_new;
  end

endmodule

FILE: sv/obbpt_back.sv
// Back end: order table, level counts, level masks and best price search.
module obbpt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  obbpt_pkg::cmd_t cmd_i,
  input  logic            cmd_valid_i,
  output logic            cmd_pop_o,
  output logic            busy_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            accepted_o,
  output logic [2:0]      status_o,
  output logic            best_bid_valid_o,
  output logic [11:0]     best_bid_o,
  output logic            best_ask_valid_o,
  output logic [11:0]     best_ask_o
);

  localparam int LW = obbpt_pkg::LVL_W;
  localparam int WW = obbpt_pkg::WORD_W;
  localparam int SN = obbpt_pkg::SUM_N;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_TBL  = 3'd2;
  localparam logic [2:0] S_LVL  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_WRD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  obbpt_pkg::entry_t tbl_mem [obbpt_pkg::ORDER_SLOTS];
  logic [obbpt_pkg::CNT_W-1:0] cnt_mem [2 << LW];
  logic [63:0] msk_mem [2 * SN];

  logic [2:0]  state_q, state_d;
  obbpt_pkg::cmd_t cur_q, cur_d;
  logic        side_q, side_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic        rm_q, rm_d;
  logic [2:0]  status_q, status_d;
  logic        bbv_q, bbv_d, bav_q, bav_d;
  logic [LW-1:0] bb_q, bb_d, ba_q, ba_d;
  logic [SN-1:0] sum_q [2];
  logic [SN-1:0] sum_d [2];
  logic [WW-1:0] w2_q, w2_d;
  logic [obbpt_pkg::ID_W:0] clr_q, clr_d;

  obbpt_pkg::entry_t tbl_rd_q;
  logic [obbpt_pkg::CNT_W-1:0] cnt_rd_q;
  logic [63:0] msk_rd_q;

  logic        out_v_q, out_v_d, acc_q, acc_d;
  logic [2:0]  ost_q, ost_d;
  logic        obv_q, obv_d, oav_q, oav_d;
  logic [11:0] ob_q, ob_d, oa_q, oa_d;

  logic        tbl_we, tbl_re, lvl_re, msk_re, cnt_we, msk_we;
  logic [obbpt_pkg::ID_W-1:0] tbl_waddr, tbl_raddr;
  obbpt_pkg::entry_t tbl_wdata;
  logic [LW:0] cnt_addr;
  logic [WW:0] msk_raddr;
  logic [obbpt_pkg::CNT_W-1:0] cnt_wdata;
  logic [63:0] msk_wdata;

  logic        rd_side;
  logic [LW-1:0] rd_lvl;
  logic [WW-1:0] w;
  logic [5:0]  b;
  logic [63:0] bitm, word_eff, new_word, srch;
  logic [obbpt_pkg::CNT_W-1:0] cnt_eff, cnt_new;
  logic [6:0]  hit;
  logic [SN-1:0] wbit, ssrch;
  logic [WW:0] shit;

  always_comb begin
    w        = lvl_q[LW-1:6];
    b        = lvl_q[5:0];
    bitm     = 64'd1 << b;
    word_eff = sum_q[side_q][w] ? msk_rd_q : 64'd0;
    cnt_eff  = ((word_eff & bitm) != 64'd0) ? cnt_rd_q : '0;
    cnt_new  = (rm_q && cnt_eff != '0) ? cnt_eff - 1'b1 : cnt_eff + 1'b1;
    new_word = rm_q ? (word_eff & ~bitm) : (word_eff | bitm);
    srch     = side_q ? (new_word & ~(bitm | (bitm - 64'd1))) : (new_word & (bitm - 64'd1));
    wbit     = SN'(1) << w;
    ssrch    = side_q ? (sum_q[side_q] & ~(wbit | (wbit - SN'(1))))
                      : (sum_q[side_q] & (wbit - SN'(1)));
    shit     = side_q ? obbpt_pkg::lo_bit_sum(ssrch) : obbpt_pkg::hi_bit_sum(ssrch);
    hit      = 7'd0;
    rd_side  = tbl_rd_q.side;
    rd_lvl   = tbl_rd_q.lvl;

    state_d  = state_q;
    cur_d    = cur_q;
    side_d   = side_q;
    lvl_d    = lvl_q;
    rm_d     = rm_q;
    status_d = status_q;
    bbv_d    = bbv_q;
    bav_d    = bav_q;
    bb_d     = bb_q;
    ba_d     = ba_q;
    sum_d    = sum_q;
    w2_d     = w2_q;
    clr_d    = clr_q;
    out_v_d  = out_v_q && !out_ready_i;
    acc_d    = acc_q;
    ost_d    = ost_q;
    obv_d    = obv_q;
    oav_d    = oav_q;
    ob_d     = ob_q;
    oa_d     = oa_q;

    cmd_pop_o = 1'b0;
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    tbl_waddr = cur_q.id;
    tbl_raddr = cmd_i.id;
    tbl_wdata = tbl_rd_q;
    lvl_re    = 1'b0;
    cnt_addr  = {side_q, lvl_q};
    msk_re    = 1'b0;
    msk_raddr = {side_q, w};
    cnt_we    = 1'b0;
    msk_we    = 1'b0;
    cnt_wdata = cnt_new;
    msk_wdata = new_word;

    unique case (state_q)
      S_CLR: begin
        tbl_we         = 1'b1;
        tbl_waddr      = clr_q[obbpt_pkg::ID_W-1:0];
        tbl_wdata      = '0;
        clr_d          = clr_q + 1'b1;
        if (clr_q == (obbpt_pkg::ID_W + 1)'(obbpt_pkg::ORDER_SLOTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          status_d  = cmd_i.pre_status;
          if (cmd_i.pre_status != obbpt_pkg::ST_OK) begin
            state_d = S_OUT;
          end else if (cmd_i.op == obbpt_pkg::OP_CLEAR) begin
            bbv_d   = 1'b0;
            bav_d   = 1'b0;
            sum_d[0] = '0;
            sum_d[1] = '0;
            state_d = S_OUT;
          end else begin
            tbl_re  = 1'b1;
            state_d = S_TBL;
          end
        end
      end
      S_TBL: begin
        priority if (!tbl_rd_q.live && cur_q.op != obbpt_pkg::OP_ADD) begin
          status_d = obbpt_pkg::ST_NOT_LIVE;
          state_d  = S_OUT;
        end else if (cur_q.op == obbpt_pkg::OP_ADD) begin
          if (tbl_rd_q.live) begin
            status_d = obbpt_pkg::ST_DUPLICATE;
            state_d  = S_OUT;
          end else begin
            tbl_we    = 1'b1;
            tbl_wdata = '{live: 1'b1, side: cur_q.side, lvl: cur_q.lvl, qty: cur_q.qty};
            side_d    = cur_q.side;
            lvl_d     = cur_q.lvl;
            rm_d      = 1'b0;
            lvl_re    = 1'b1;
            cnt_addr  = {cur_q.side, cur_q.lvl};
            msk_re    = 1'b1;
            msk_raddr = {cur_q.side, cur_q.lvl[LW-1:6]};
            state_d   = S_LVL;
          end
        end else if (cur_q.op == obbpt_pkg::OP_REDUCE && cur_q.qty >= tbl_rd_q.qty) begin
          status_d = obbpt_pkg::ST_NOT_REDUCTION;
          state_d  = S_OUT;
        end else if (cur_q.op == obbpt_pkg::OP_REDUCE && cur_q.qty != '0) begin
          tbl_we        = 1'b1;
          tbl_wdata.qty = cur_q.qty;
          state_d       = S_OUT;
        end else begin
          tbl_we         = 1'b1;
          tbl_wdata.live = 1'b0;
          side_d    = rd_side;
          lvl_d     = rd_lvl;
          rm_d      = 1'b1;
          lvl_re    = 1'b1;
          cnt_addr  = {rd_side, rd_lvl};
          msk_re    = 1'b1;
          msk_raddr = {rd_side, rd_lvl[LW-1:6]};
          state_d   = S_LVL;
        end
      end
      S_LVL: begin
        cnt_we  = 1'b1;
        state_d = S_OUT;
        if (!rm_q) begin
          msk_we = 1'b1;
          sum_d[side_q][w] = 1'b1;
          if (!side_q && (!bbv_q || lvl_q > bb_q)) begin
            bbv_d = 1'b1;
            bb_d  = lvl_q;
          end
          if (side_q && (!bav_q || lvl_q < ba_q)) begin
            bav_d = 1'b1;
            ba_d  = lvl_q;
          end
        end else if (cnt_new == '0) begin
          msk_we = 1'b1;
          sum_d[side_q][w] = new_word != 64'd0;
          hit = side_q ? obbpt_pkg::lo_bit64(srch) : obbpt_pkg::hi_bit64(srch);
          if (!side_q && bbv_q && bb_q == lvl_q) begin
            if (hit[6]) bb_d = {w, hit[5:0]};
            else state_d = S_SUM;
          end
          if (side_q && bav_q && ba_q == lvl_q) begin
            if (hit[6]) ba_d = {w, hit[5:0]};
            else state_d = S_SUM;
          end
        end
      end
      S_SUM: begin
        if (shit[WW]) begin
          w2_d      = shit[WW-1:0];
          msk_re    = 1'b1;
          msk_raddr = {side_q, shit[WW-1:0]};
          state_d   = S_WRD;
        end else begin
          if (side_q) bav_d = 1'b0;
          else bbv_d = 1'b0;
          state_d = S_OUT;
        end
      end
      S_WRD: begin
        hit = side_q ? obbpt_pkg::lo_bit64(msk_rd_q) : obbpt_pkg::hi_bit64(msk_rd_q);
        if (side_q) ba_d = {w2_q, hit[5:0]};
        else bb_d = {w2_q, hit[5:0]};
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_v_q || out_ready_i) begin
          out_v_d = 1'b1;
          acc_d   = status_q == obbpt_pkg::ST_OK;
          ost_d   = status_q;
          obv_d   = bbv_q;
          oav_d   = bav_q;
          ob_d    = bbv_q ? 12'(bb_q) : 12'd0;
          oa_d    = bav_q ? 12'(ba_q) : 12'd0;
          if (cur_q.op == obbpt_pkg::OP_CLEAR && status_q == obbpt_pkg::ST_OK) begin
            clr_d   = '0;
            state_d = S_CLR;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      bbv_q   <= 1'b0;
      bav_q   <= 1'b0;
      sum_q[0] <= '0;
      sum_q[1] <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      bbv_q   <= bbv_d;
      bav_q   <= bav_d;
      sum_q   <= sum_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    side_q   <= side_d;
    lvl_q    <= lvl_d;
    rm_q     <= rm_d;
    status_q <= status_d;
    bb_q     <= bb_d;
    ba_q     <= ba_d;
    w2_q     <= w2_d;
    acc_q    <= acc_d;
    ost_q    <= ost_d;
    obv_q    <= obv_d;
    oav_q    <= oav_d;
    ob_q     <= ob_d;
    oa_q     <= oa_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (tbl_re) tbl_rd_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_addr] <= cnt_wdata;
    if (lvl_re) cnt_rd_q <= cnt_mem[cnt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (msk_we) msk_mem[msk_raddr] <= msk_wdata;
    if (msk_re) msk_rd_q <= msk_mem[msk_raddr];
  end

  assign busy_o           = state_q == S_CLR;
  assign out_valid_o      = out_v_q;
  assign accepted_o       = acc_q;
  assign status_o         = ost_q;
  assign best_bid_valid_o = obv_q;
  assign best_bid_o       = ob_q;
  assign best_ask_valid_o = oav_q;
  assign best_ask_o       = oa_q;

endmodule

FILE: sv/obbpt_checker.sv
// Port-level assertions for the order book tracker, bound to the top level.
`include "assert_macros.svh"

module obbpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        accepted_o,
  input logic [2:0]  status_o,
  input logic        best_bid_valid_o,
  input logic [11:0] best_bid_o,
  input logic        best_ask_valid_o,
  input logic [11:0] best_ask_o
);

  `OBBPT_ASSERT_SAME(a_acc_status, out_valid_o, accepted_o == (status_o == obbpt_pkg::ST_OK))
  `OBBPT_ASSERT_SAME(a_bid_zero, out_valid_o && !best_bid_valid_o, best_bid_o == 12'd0)
  `OBBPT_ASSERT_SAME(a_ask_zero, out_valid_o && !best_ask_valid_o, best_ask_o == 12'd0)
  `OBBPT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o))

endmodule

bind order_book_best_price_tracker obbpt_checker u_obbpt_checker (.*);
